// File: rtl/thc_pkg.sv
// Shared types, constants and tables for the tilt-compensated heading unit.
// No dependencies.
package thc_pkg;

    localparam int DefaultSteps = 16;
    localparam int AtanEntries  = 24;

    // rotation datapath: Q30 sine/cosine plus guard, binary angle plus guard
    localparam int RW = 34;
    // vectoring datapath: raw count times Q30, plus growth and sign
    localparam int XW = 51;
    localparam int ZW = 35;
    localparam int MW = 16;

    localparam logic signed [RW-1:0] GainQ30     = RW'(652032874);
    localparam logic signed [RW-1:0] QuarterTurn = RW'(64'sd1073741824);
    localparam logic signed [RW-1:0] HalfTurnR   = RW'(64'sd2147483648);
    localparam logic signed [ZW-1:0] HalfTurnV   = ZW'(64'sd2147483648);
    localparam logic [15:0]          HeadingLimit = 16'd23040;

    // angle / 45 by reciprocal, exact for magnitudes up to 2^16
    localparam logic [15:0] DivRecip = 16'd46604;
    localparam int          DivShift = 21;
    localparam int          AngDiv   = 45;

    localparam logic [31:0] ATAN_TURNS [AtanEntries] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } vec_t;

    typedef struct packed {
        logic signed [MW-1:0] x;
        logic signed [MW-1:0] y;
        logic signed [MW-1:0] z;
        logic                 neg_p;
        logic                 neg_r;
    } side_t;

    typedef logic [63:0][21:0] frac_tab_t;

    // entries at and above 45 are never addressed
    function automatic frac_tab_t build_frac_tab();
        frac_tab_t tab;
        for (int r = 0; r < 64; r++) begin
            tab[r] = 22'((64'(r) * 64'd4194304 + 64'd22) / 64'(AngDiv));
        end
        return tab;
    endfunction

    localparam frac_tab_t FracTurn = build_frac_tab();

    // (r * 2^22 + 22) / 45 for a remainder r below 45, from a constant table
    function automatic logic [21:0] frac_turn(input logic [5:0] r);
        return FracTurn[r];
    endfunction

endpackage

// File: rtl/thc_rot_cell.sv
// One CORDIC rotation step (sine/cosine generation) with its output register.
// Depends on thc_pkg.
module thc_rot_cell #(
    parameter int STEP = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  thc_pkg::rot_t  rot_in,
    output thc_pkg::rot_t  rot_out
);

    localparam logic signed [thc_pkg::RW-1:0] Atan =
        thc_pkg::RW'(thc_pkg::ATAN_TURNS[STEP]);

    thc_pkg::rot_t rot_reg;
    thc_pkg::rot_t rot_next;
    logic signed [thc_pkg::RW-1:0] dx;
    logic signed [thc_pkg::RW-1:0] dy;

    always_comb begin
        dx = rot_in.y >>> STEP;
        dy = rot_in.x >>> STEP;
        if (!rot_in.z[thc_pkg::RW-1]) begin
            rot_next.x = rot_in.x - dx;
            rot_next.y = rot_in.y + dy;
            rot_next.z = rot_in.z - Atan;
        end else begin
            rot_next.x = rot_in.x + dx;
            rot_next.y = rot_in.y - dy;
            rot_next.z = rot_in.z + Atan;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg <= rot_next;
        end
    end

    assign rot_out = rot_reg;

endmodule

// File: rtl/thc_vec_cell.sv
// One CORDIC vectoring step (atan2) with its output register.
// Depends on thc_pkg.
module thc_vec_cell #(
    parameter int STEP = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  thc_pkg::vec_t  vec_in,
    output thc_pkg::vec_t  vec_out
);

    localparam logic signed [thc_pkg::ZW-1:0] Atan =
        thc_pkg::ZW'(thc_pkg::ATAN_TURNS[STEP]);

    thc_pkg::vec_t vec_reg;
    thc_pkg::vec_t vec_next;
    logic signed [thc_pkg::XW-1:0] dx;
    logic signed [thc_pkg::XW-1:0] dy;

    always_comb begin
        dx = vec_in.y >>> STEP;
        dy = vec_in.x >>> STEP;
        vec_next.zero = vec_in.zero;
        if (vec_in.y > 0) begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + Atan;
        end else begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - Atan;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

// File: rtl/tilt_compensated_heading_unit.sv
// Tilt-compensated compass heading: top level, pipeline control and tilt math.
// Depends on thc_pkg, thc_rot_cell, thc_vec_cell.
//
// Takes one transaction per clock when the result side keeps up: the block is a
// single pipeline of 2*N+8 register stages (N = min(CORDIC_STEPS, 24)), with a
// throughput of one heading per cycle. Two angle-conversion stages feed a row
// of N rotation cells that form sine and cosine of pitch and roll side by side;
// five stages of multiply and add build the tilt-corrected components, a row
// of N vectoring cells forms atan2, and the last stage rounds to 1/128 degree
// into the output register. Any stage holding no transaction fills while a
// later one stalls.
module tilt_compensated_heading_unit #(
    parameter int CORDIC_STEPS = thc_pkg::DefaultSteps
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_mag_x,
    input  logic signed [15:0] s_mag_y,
    input  logic signed [15:0] s_mag_z,
    input  logic signed [15:0] s_pitch_angle,
    input  logic signed [15:0] s_roll_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_heading_angle
);

    localparam int N  = (CORDIC_STEPS > thc_pkg::AtanEntries) ?
                        thc_pkg::AtanEntries : CORDIC_STEPS;
    localparam int NV = 2 * N + 8;
    localparam int RW = thc_pkg::RW;
    localparam int XW = thc_pkg::XW;
    localparam int ZW = thc_pkg::ZW;

    // stage slots
    localparam int SlotS1  = 1;
    localparam int SlotRot = 2;
    localparam int SlotS2  = N + 2;
    localparam int SlotM1  = N + 3;
    localparam int SlotM2  = N + 4;
    localparam int SlotM3  = N + 5;
    localparam int SlotP   = N + 6;
    localparam int SlotVec = N + 7;
    localparam int SlotOut = NV - 1;

    logic [NV-1:0] valid_reg;
    logic [NV:0]   rdy;

    always_comb begin
        rdy[NV] = m_ready;
        for (int k = NV - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NV; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[SlotOut];

    // ---------------- stage 0: |angle| / 45 quotient ----------------
    logic [15:0] pm_abs, rm_abs;
    logic [31:0] pk_prod, rk_prod;
    logic [15:0] pm_reg, rm_reg;
    logic [9:0]  pk_reg, rk_reg;
    logic        psgn_reg, rsgn_reg;
    thc_pkg::side_t side0_reg;

    always_comb begin
        pm_abs  = s_pitch_angle[15] ? 16'(-s_pitch_angle) : 16'(s_pitch_angle);
        rm_abs  = s_roll_angle[15]  ? 16'(-s_roll_angle)  : 16'(s_roll_angle);
        pk_prod = 32'(pm_abs) * 32'(thc_pkg::DivRecip);
        rk_prod = 32'(rm_abs) * 32'(thc_pkg::DivRecip);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            pm_reg   <= pm_abs;
            rm_reg   <= rm_abs;
            pk_reg   <= pk_prod[thc_pkg::DivShift +: 10];
            rk_reg   <= rk_prod[thc_pkg::DivShift +: 10];
            psgn_reg <= s_pitch_angle[15];
            rsgn_reg <= s_roll_angle[15];
            side0_reg.x     <= s_mag_x;
            side0_reg.y     <= s_mag_y;
            side0_reg.z     <= s_mag_z;
            side0_reg.neg_p <= 1'b0;
            side0_reg.neg_r <= 1'b0;
        end
    end

    // ---------------- stage 1: binary angle, half-plane fold ----------------
    thc_pkg::rot_t rotp_pipe [N+1];
    thc_pkg::rot_t rotr_pipe [N+1];
    thc_pkg::side_t side_pipe [N+1];

    function automatic logic [RW:0] to_turn(input logic [15:0] m, input logic [9:0] k,
                                            input logic sgn);
        logic [15:0]          r;
        logic [32:0]          q;
        logic [32:0]          ba;
        logic signed [RW-1:0] z;
        logic                 neg;
        r   = m - 16'(k) * 16'(thc_pkg::AngDiv);
        q   = {1'b0, k, 22'd0} + 33'(thc_pkg::frac_turn(r[5:0]));
        ba  = sgn ? -q : q;
        z   = RW'($signed(ba[31:0]));
        neg = 1'b0;
        if (z > thc_pkg::QuarterTurn) begin
            z   = z - thc_pkg::HalfTurnR;
            neg = 1'b1;
        end else if (z < -thc_pkg::QuarterTurn) begin
            z   = z + thc_pkg::HalfTurnR;
            neg = 1'b1;
        end
        return {neg, z};
    endfunction

    logic [RW:0] pturn, rturn;

    always_comb begin
        pturn = to_turn(pm_reg, pk_reg, psgn_reg);
        rturn = to_turn(rm_reg, rk_reg, rsgn_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy[SlotS1]) begin
            rotp_pipe[0].x <= thc_pkg::GainQ30;
            rotp_pipe[0].y <= '0;
            rotp_pipe[0].z <= pturn[RW-1:0];
            rotr_pipe[0].x <= thc_pkg::GainQ30;
            rotr_pipe[0].y <= '0;
            rotr_pipe[0].z <= rturn[RW-1:0];
            side_pipe[0].x     <= side0_reg.x;
            side_pipe[0].y     <= side0_reg.y;
            side_pipe[0].z     <= side0_reg.z;
            side_pipe[0].neg_p <= pturn[RW];
            side_pipe[0].neg_r <= rturn[RW];
        end
    end

    // ---------------- rotation cells ----------------
    for (genvar k = 0; k < N; k++) begin : g_rot
        thc_rot_cell #(.STEP(k)) u_pitch (
            .aclk    (aclk),
            .en      (rdy[SlotRot+k]),
            .rot_in  (rotp_pipe[k]),
            .rot_out (rotp_pipe[k+1])
        );
        thc_rot_cell #(.STEP(k)) u_roll (
            .aclk    (aclk),
            .en      (rdy[SlotRot+k]),
            .rot_in  (rotr_pipe[k]),
            .rot_out (rotr_pipe[k+1])
        );
        always_ff @(posedge aclk) begin
            if (rdy[SlotRot+k]) begin
                side_pipe[k+1] <= side_pipe[k];
            end
        end
    end

    // ---------------- stage S2: undo half-plane fold ----------------
    logic signed [RW-1:0] sp_reg, cp_reg, sr_reg, cr_reg;
    logic signed [15:0]   mx2_reg, my2_reg, mz2_reg;

    always_ff @(posedge aclk) begin
        if (rdy[SlotS2]) begin
            sp_reg  <= side_pipe[N].neg_p ? -rotp_pipe[N].y : rotp_pipe[N].y;
            cp_reg  <= side_pipe[N].neg_p ? -rotp_pipe[N].x : rotp_pipe[N].x;
            sr_reg  <= side_pipe[N].neg_r ? -rotr_pipe[N].y : rotr_pipe[N].y;
            cr_reg  <= side_pipe[N].neg_r ? -rotr_pipe[N].x : rotr_pipe[N].x;
            mx2_reg <= side_pipe[N].x;
            my2_reg <= side_pipe[N].y;
            mz2_reg <= side_pipe[N].z;
        end
    end

    // ---------------- M1: first products ----------------
    logic signed [2*RW-1:0] srsp_reg, srcp_reg;
    logic signed [XW-1:0]   xc_reg, zs_reg, yc_reg;
    logic signed [15:0]     mx3_reg, mz3_reg;

    always_ff @(posedge aclk) begin
        if (rdy[SlotM1]) begin
            srsp_reg <= sr_reg * sp_reg;
            srcp_reg <= sr_reg * cp_reg;
            xc_reg   <= XW'(mx2_reg * cp_reg);
            zs_reg   <= XW'(mz2_reg * sp_reg);
            yc_reg   <= XW'(my2_reg * cr_reg);
            mx3_reg  <= mx2_reg;
            mz3_reg  <= mz2_reg;
        end
    end

    // ---------------- M2: Xh, second products ----------------
    logic signed [2*RW-1:0] srsp_sh, srcp_sh;
    logic signed [XW-1:0]   xh_m2_reg, xs_reg, zc_reg, yc2_reg;

    always_comb begin
        srsp_sh = srsp_reg >>> 30;
        srcp_sh = srcp_reg >>> 30;
    end

    always_ff @(posedge aclk) begin
        if (rdy[SlotM2]) begin
            xh_m2_reg <= xc_reg + zs_reg;
            xs_reg    <= XW'(mx3_reg * $signed(srsp_sh[RW-1:0]));
            zc_reg    <= XW'(mz3_reg * $signed(srcp_sh[RW-1:0]));
            yc2_reg   <= yc_reg;
        end
    end

    // ---------------- M3: Yh ----------------
    logic signed [XW-1:0] xh_reg, yh_reg;

    always_ff @(posedge aclk) begin
        if (rdy[SlotM3]) begin
            xh_reg <= xh_m2_reg;
            yh_reg <= xs_reg + yc2_reg - zc_reg;
        end
    end

    // ---------------- P: left half-plane turn ----------------
    thc_pkg::vec_t vec_pipe [N+1];

    always_ff @(posedge aclk) begin
        if (rdy[SlotP]) begin
            vec_pipe[0].zero <= (xh_reg == '0) && (yh_reg == '0);
            if (xh_reg[XW-1]) begin
                vec_pipe[0].x <= -xh_reg;
                vec_pipe[0].y <= -yh_reg;
                vec_pipe[0].z <= yh_reg[XW-1] ? -thc_pkg::HalfTurnV : thc_pkg::HalfTurnV;
            end else begin
                vec_pipe[0].x <= xh_reg;
                vec_pipe[0].y <= yh_reg;
                vec_pipe[0].z <= '0;
            end
        end
    end

    // ---------------- vectoring cells ----------------
    for (genvar k = 0; k < N; k++) begin : g_vec
        thc_vec_cell #(.STEP(k)) u_vec (
            .aclk    (aclk),
            .en      (rdy[SlotVec+k]),
            .vec_in  (vec_pipe[k]),
            .vec_out (vec_pipe[k+1])
        );
    end

    // ---------------- output: round to 1/128 degree, saturate ----------------
    logic [ZW-1:0]   z_abs;
    logic [ZW+6:0]   z_scaled;
    logic [ZW+6:0]   q_full;
    logic [15:0]     q_sat;
    logic signed [15:0] heading_next;
    logic signed [15:0] heading_reg;

    always_comb begin
        z_abs    = vec_pipe[N].z[ZW-1] ? ZW'(-vec_pipe[N].z) : ZW'(vec_pipe[N].z);
        z_scaled = ((ZW+7)'(z_abs) << 5) + ((ZW+7)'(z_abs) << 3)
                 + ((ZW+7)'(z_abs) << 2) + (ZW+7)'(z_abs) + (ZW+7)'(2097152);
        q_full   = z_scaled >> 22;
        q_sat    = (q_full > (ZW+7)'(thc_pkg::HeadingLimit)) ?
                   thc_pkg::HeadingLimit : q_full[15:0];
        if (vec_pipe[N].zero) begin
            heading_next = '0;
        end else if (vec_pipe[N].z[ZW-1]) begin
            heading_next = -$signed(q_sat);
        end else begin
            heading_next = $signed(q_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[SlotOut]) begin
            heading_reg <= heading_next;
        end
    end

    assign m_heading_angle = heading_reg;

endmodule

// File: bench/heading_checker.sv
// Checker for the tilt-compensated heading unit: watches both channels,
// predicts each heading and compares it with the output. Depends on nothing else.
`timescale 1ns / 100ps
module heading_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_mag_x,
    input  logic signed [15:0] s_mag_y,
    input  logic signed [15:0] s_mag_z,
    input  logic signed [15:0] s_pitch_angle,
    input  logic signed [15:0] s_roll_angle,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_heading_angle,
    output int                 fail_count,
    output int                 pending
);

    localparam longint HalfTurn = 64'sd2147483648;
    localparam longint QuarterTurn = 64'sd1073741824;

    longint atan_tab [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    logic signed [15:0] heading_q [$];

    function automatic int num_steps();
        return (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    endfunction

    // sine and cosine in Q30 of an angle in 1/128 degree
    function automatic void angle_sin_cos(input longint a, output longint s,
                                          output longint c);
        longint m, q, z, x, y, dx, dy;
        logic [31:0] w;
        bit neg;
        m = a < 0 ? -a : a;
        q = (m * 4194304 + 22) / 45;
        w = 32'(a < 0 ? -q : q);
        z = longint'($signed(w));
        neg = 0;
        x = 652032874;
        y = 0;
        if (z > QuarterTurn) begin
            z -= HalfTurn;
            neg = 1;
        end else if (z < -QuarterTurn) begin
            z += HalfTurn;
            neg = 1;
        end
        for (int i = 0; i < num_steps(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function automatic logic signed [15:0] predict_heading(
        longint mx, longint my, longint mz, longint pa, longint ra);
        longint sp, cp, sr, cr, srsp, srcp, xh, yh, x, y, z, m, q, dx, dy;
        angle_sin_cos(pa, sp, cp);
        angle_sin_cos(ra, sr, cr);
        srsp = (sr * sp) >>> 30;
        srcp = (sr * cp) >>> 30;
        xh = mx * cp + mz * sp;
        yh = mx * srsp + my * cr - mz * srcp;
        if (xh == 0 && yh == 0) return 16'sd0;
        if (xh < 0) begin
            x = -xh; y = -yh;
            z = (yh >= 0) ? HalfTurn : -HalfTurn;
        end else begin
            x = xh; y = yh; z = 0;
        end
        for (int i = 0; i < num_steps(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        m = z < 0 ? -z : z;
        q = (m * 45 + 2097152) >>> 22;
        if (q > 23040) q = 23040;
        if (z < 0) q = -q;
        return 16'(q);
    endfunction

    assign pending = heading_q.size();

    always @(posedge aclk) begin
        logic signed [15:0] exp_heading;
        if (!aresetn) begin
            fail_count <= 0;
            heading_q.delete();
        end else begin
            if (s_valid && s_ready)
                heading_q.push_back(predict_heading(s_mag_x, s_mag_y, s_mag_z,
                                                    s_pitch_angle, s_roll_angle));
            if (m_valid && m_ready) begin
                if (heading_q.size() == 0) begin
                    $display("%0t: unexpected heading transaction, actual %0d",
                             $time, m_heading_angle);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_heading = heading_q.pop_front();
                    if (exp_heading !== m_heading_angle) begin
                        $display("%0t: heading mismatch, expected %0d actual %0d",
                                 $time, exp_heading, m_heading_angle);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: bench/tilt_compensated_heading_unit_test.sv
// Testbench top for the tilt-compensated heading unit: clock, reset, stimulus
// and verdict. Depends on thc_pkg, the block and heading_checker.
`timescale 1ns / 100ps
module tilt_compensated_heading_unit_test;

    localparam int Steps = thc_pkg::DefaultSteps;
    localparam int Latency = 2 * Steps + 8;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_mag_x = '0;
    logic signed [15:0] s_mag_y = '0;
    logic signed [15:0] s_mag_z = '0;
    logic signed [15:0] s_pitch_angle = '0;
    logic signed [15:0] s_roll_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_heading_angle;
    int                 fail_count;
    int                 pending;
    bit                 calm_rx = 0;
    bit                 hold_rx = 0;
    bit                 calm_tx = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    tilt_compensated_heading_unit #(.CORDIC_STEPS(Steps)) u_top (.*);

    heading_checker #(.CORDIC_STEPS(Steps)) u_checker (.*);

    // receiver: random stalls, with a quiet stretch and a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_rx) m_ready <= 1'b0;
        else m_ready <= calm_rx || ($urandom_range(99) >= 25);
    end

    initial begin
        forever begin
            wait (aresetn);
            repeat (300) @(posedge aclk);
            hold_rx = 1;
            repeat (200) @(posedge aclk);
            hold_rx = 0;
            repeat (500) @(posedge aclk);
            calm_rx = 1;
            repeat (600) @(posedge aclk);
            calm_rx = 0;
            wait (0);
        end
    end

    function automatic logic signed [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(7))
            0: return 16'sd23040;
            1: return -16'sd23040;
            2: return 16'(int'($urandom_range(4)) * 5760 - 11520);
            3: return 16'($urandom);
            default: return 16'(int'($urandom_range(46080)) - 23040);
        endcase
    endfunction

    task automatic send_item(input logic signed [15:0] mx, my, mz, pa, ra);
        while (!calm_tx && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mag_x <= mx;
        s_mag_y <= my;
        s_mag_z <= mz;
        s_pitch_angle <= pa;
        s_roll_angle <= ra;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: extremes, zero vector, axis cases, wrap and fold of angles
        send_item(0, 0, 0, 0, 0);
        send_item(0, 0, 1000, 0, 0);
        send_item(1000, 0, 0, 0, 0);
        send_item(-1000, 0, 0, 0, 0);
        send_item(-1000, 1, 0, 0, 0);
        send_item(-1000, -1, 0, 0, 0);
        send_item(0, 1000, 0, 0, 0);
        send_item(0, -1000, 0, 0, 0);
        send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(16'sh7fff, 16'sh8000, 16'sh7fff, 23040, -23040);
        send_item(16'sh8000, 16'sh7fff, 16'sh8000, -23040, 23040);
        send_item(500, 300, -200, 11520, -11520);
        send_item(500, 300, -200, 11521, -11521);
        send_item(500, 300, -200, 30000, -30000);
        send_item(-32, 77, 900, 17000, 5000);
        send_item(1, -1, 1, -1, 1);
        send_item(-1, 0, 0, 16'sh5555, 16'shaaaa);
        s_valid <= 1'b0;
        // pause until drained
        wait (pending == 0);
        @(posedge aclk);
        for (int i = 0; i < 1100; i++) begin
            calm_tx = (i >= 700 && i < 800);
            send_item(pick_word(), pick_word(), pick_word(), pick_angle(), pick_angle());
        end
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (Latency + 10) @(posedge aclk);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
